>>> rtl/core/sha256_pkg.sv
// shared constants and functions for the sha-256 digest block
package sha256_pkg;

    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 61;
    localparam int ROUNDS     = 64;
    localparam int IN_TDATA_W = 8;
    localparam int IN_TUSER_W = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [0:63];
        begin
            k = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            return k[t];
        end
    endfunction

    // controls from sequencer to round unit
    typedef struct packed {
        logic       load;    // copy chain into working words
        logic       round;   // run one round
        logic [5:0] t;       // round index
    } rnd_ctrl_t;

endpackage

>>> rtl/core/sha256_message_digest.sv
// sha-256 digest over a byte stream, top level
// Takes one message byte per request; s_tuser[0] is has_byte, s_tlast ends the
// message. A byte that does not complete a block is only stored. The 64th byte of a
// block starts the compression: a load of the chain into the working words, 64
// rounds in the shared round unit, one per cycle, and an add into the chain. On the
// last request the padding bytes are written one per cycle into the block (up to 64
// in all), and each padded block is compressed in turn, one or two of them, the
// second one only when the 0x80 byte lands after byte 55. The eight digest words
// then leave on the master side, one per request, word 0 first. Input is not ready
// during all of this.
module sha256_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [7:0]  s_tuser,   // has_byte, 7 zero bits
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [7:0]  m_tuser,   // word_index[2:0], 5 zero bits
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]   state_reg;
    logic [31:0]  chain_reg [0:7];
    logic [31:0]  win_reg [0:15];
    logic [5:0]   fill_reg;
    logic [60:0]  count_reg;
    logic [5:0]   rnd_reg;
    logic         fin_reg;      // finishing a message
    logic         mark_reg;     // 0x80 already placed
    logic         lenblk_reg;   // current block carries the length
    logic [2:0]   oidx_reg;
    logic [255:0] chain_flat;
    logic [255:0] work;
    logic [31:0]  w_cur;
    logic [31:0]  w15;
    logic [31:0]  w2;
    logic [31:0]  ws0;
    logic [31:0]  ws1;
    logic [31:0]  w_new;
    logic [3:0]   idx15;
    logic [3:0]   idx7;
    logic [3:0]   idx2;
    rnd_ctrl_t    ctrl;
    logic         s_acc;
    logic [7:0]   pbyte;
    logic [63:0]  bits;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign bits     = {count_reg, 3'b000};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_flat[255 - 32*i -: 32] = chain_reg[i];
        end
    end

    // message schedule for the current round
    always_comb
    begin
        idx15 = rnd_reg[3:0] - 4'd15;
        idx7  = rnd_reg[3:0] - 4'd7;
        idx2  = rnd_reg[3:0] - 4'd2;
        w15   = win_reg[idx15];
        w2    = win_reg[idx2];
        ws0   = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        ws1   = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w_new = win_reg[rnd_reg[3:0]] + ws0 + win_reg[idx7] + ws1;
        w_cur = (rnd_reg >= 6'd16) ? w_new : win_reg[rnd_reg[3:0]];
    end

    assign ctrl = {state_reg == ST_LOAD, state_reg == ST_ROUND, rnd_reg};

    sha256_round u_round (
        .clk   (clk),
        .ctrl  (ctrl),
        .chain (chain_flat),
        .w_in  (w_cur),
        .work  (work)
    );

    // byte written during padding
    assign pbyte = mark_reg ? 8'h00 : PAD_BYTE;

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            count_reg  <= '0;
            rnd_reg    <= '0;
            fin_reg    <= 1'b0;
            mark_reg   <= 1'b0;
            lenblk_reg <= 1'b0;
            oidx_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        fin_reg <= s_tlast;
                        if (s_tuser[0])
                        begin
                            fill_reg  <= fill_reg + 6'd1;
                            count_reg <= count_reg + 61'd1;
                            if (fill_reg == 6'd63)
                            begin
                                state_reg <= ST_LOAD;
                            end
                            else if (s_tlast)
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                        else if (s_tlast)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    // first pad step places 0x80, later ones zero
                    fill_reg <= fill_reg + 6'd1;
                    mark_reg <= 1'b1;
                    if (fill_reg == 6'd55)
                    begin
                        lenblk_reg <= 1'b1;
                        state_reg  <= ST_LOAD;
                    end
                    else if (fill_reg == 6'd63)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    rnd_reg   <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work[255 - 32*i -: 32];
                    end
                    if (!fin_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (lenblk_reg)
                    begin
                        oidx_reg  <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_PAD;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= init_hash(3'(i));
                            end
                            count_reg  <= '0;
                            fill_reg   <= '0;
                            fin_reg    <= 1'b0;
                            mark_reg   <= 1'b0;
                            lenblk_reg <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // block window: byte packing, padding and schedule expansion
    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser[0])
        begin
            case (fill_reg[1:0])
                2'd0: win_reg[fill_reg[5:2]] <= {s_tdata, 24'd0};
                2'd1: win_reg[fill_reg[5:2]][23:16] <= s_tdata;
                2'd2: win_reg[fill_reg[5:2]][15:8] <= s_tdata;
                default: win_reg[fill_reg[5:2]][7:0] <= s_tdata;
            endcase
        end
        else if (state_reg == ST_PAD)
        begin
            case (fill_reg[1:0])
                2'd0: win_reg[fill_reg[5:2]] <= {pbyte, 24'd0};
                2'd1: win_reg[fill_reg[5:2]][23:16] <= pbyte;
                2'd2: win_reg[fill_reg[5:2]][15:8] <= pbyte;
                default: win_reg[fill_reg[5:2]][7:0] <= pbyte;
            endcase
            // last pad byte of the length block, length words go in too
            if (fill_reg == 6'd55)
            begin
                win_reg[14] <= bits[63:32];
                win_reg[15] <= bits[31:0];
            end
        end
        else if (state_reg == ST_ROUND && rnd_reg >= 6'd16)
        begin
            win_reg[rnd_reg[3:0]] <= w_new;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[oidx_reg];
    assign m_tuser  = {5'd0, oidx_reg};
    assign m_tlast  = (oidx_reg == 3'd7);

`ifndef SYNTHESIS
    // no input taken while busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while busy");
    // a round run lasts until the add
    a_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("round sequence broken");
    // output words advance only on a taken request
    a_oidx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(oidx_reg))
        else $error("digest index moved while stalled");
`endif

endmodule

>>> rtl/core/sha256_round.sv
// one sha-256 round per cycle while ctrl.round is set, over the working words, with the schedule word from w_in
module sha256_round (
    input  logic                   clk,
    input  sha256_pkg::rnd_ctrl_t  ctrl,
    input  logic [255:0]           chain,
    input  logic [31:0]            w_in,
    output logic [255:0]           work
);
    import sha256_pkg::*;

    logic [31:0] v_reg [0:7];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s1;
    logic [31:0] s0;
    logic [31:0] ch;
    logic [31:0] maj;

    // round function
    always_comb
    begin
        s1  = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
            ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        s0  = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
            ^ {v_reg[0][21:0], v_reg[0][31:22]};
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + s1 + ch + round_k(ctrl.t) + w_in;
        t2  = s0 + maj;
    end

    // working word update
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= chain[255 - 32*i -: 32];
            end
        end
        else if (ctrl.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign work = {v_reg[0], v_reg[1], v_reg[2], v_reg[3],
                   v_reg[4], v_reg[5], v_reg[6], v_reg[7]};

endmodule

>>> tb/tb_sha256_message_digest.sv
// self-checking testbench for the sha-256 byte stream digest block
module tb_sha256_message_digest;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    // one digest word as it leaves the block
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    // holds expected digest words and compares them in order
    class digest_scoreboard;
        digest_word_t pending[$];
        int errors;

        function void note_request(digest_word_t words[8]);
            for (int i = 0; i < 8; i++)
                pending = {pending, words[i]};
        endfunction

        function void check_word(digest_word_t got);
            digest_word_t want;
            if (pending.size() == 0) begin
                $error("digest word with nothing pending: %h", got.word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.word !== want.word) begin
                $error("digest_word expected %h actual %h", want.word, got.word);
                errors++;
            end
            if (got.index !== want.index) begin
                $error("word_index expected %0d actual %0d", want.index, got.index);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_word expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte
    logic [7:0]  s_tuser;   // has_byte, 7 zero bits
    logic        s_tlast;   // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // digest_word
    logic [7:0]  m_tuser;   // word_index[2:0], 5 zero bits
    logic        m_tlast;   // last_word

    sha256_message_digest u_dut (.*);

    // predictor state
    logic [31:0] hash_state [8];
    logic [31:0] block_words [16];
    logic [5:0]  fill_count;
    logic [60:0] byte_count;

    digest_scoreboard digests;
    bit hold_off;
    bit stim_done;
    int req_count;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of the current block into the hash state
    function automatic void compress_block();
        logic [31:0] v [8];
        logic [31:0] w [16];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 16; i++) w[i] = block_words[i];
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
                s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
                w[t&15] = w[t&15] + s0 + w[(t-7)&15] + s1;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t&15];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endfunction

    function automatic void place_byte(int pos, logic [7:0] b);
        block_words[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
    endfunction

    function automatic void digest_reset();
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        fill_count = '0;
        byte_count = '0;
    endfunction

    // advance the predictor by one accepted request
    function automatic void digest_step(logic [7:0] b, logic has, logic fin);
        int pos;
        logic [63:0] bits;
        digest_word_t words[8];
        if (has) begin
            place_byte(int'(fill_count), b);
            fill_count = fill_count + 6'd1;
            byte_count = byte_count + 61'd1;
            if (fill_count == 6'd0) compress_block();
        end
        if (!fin) return;
        pos = int'(fill_count);
        place_byte(pos, PAD_BYTE);
        pos++;
        while (pos != 56) begin
            if (pos == 64) begin
                compress_block();
                pos = 0;
            end
            place_byte(pos, 8'h00);
            pos++;
        end
        bits = {byte_count, 3'b000};
        block_words[14] = bits[63:32];
        block_words[15] = bits[31:0];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            words[i].word = hash_state[i];
            words[i].index = i[2:0];
            words[i].last = (i == 7);
        end
        digests.note_request(words);
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
        fill_count = '0;
        byte_count = '0;
    endfunction

    // offer one request, with a random gap first at burst ends
    int burst_left;
    task automatic send_request(logic [7:0] b, logic has, logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {7'b0, has};
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        digest_step(b, has, fin);
        req_count++;
    endtask

    task automatic send_message(int len, bit use_empty_end, int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom_range(0, 255));
            endcase
            // some noise requests that carry no byte
            if (mode > 1 && $urandom_range(0, 15) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(b, 1'b1, !use_empty_end && (i == len - 1));
        end
        if (use_empty_end || len == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // receiver stall pattern plus one long hold-off
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= !hold_off && ($urandom_range(0, 3) != 0 || stim_done);
        end
    end

    // check results on acceptance
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            digests.check_word('{m_tdata, m_tuser[2:0], m_tlast});
    end

    // long hold-off counted in its own process
    initial begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_off <= 1'b0;
    end

    // stimulus
    initial begin
        int len;
        digests = new();
        digest_reset();
        stim_done = 1'b0;
        burst_left = 0;
        req_count = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty message, single extreme bytes, short messages, an empty end and a stray no-byte request
        send_message(0, 1'b1, 2);
        send_message(1, 1'b0, 0);
        send_message(1, 1'b0, 1);
        send_message(3, 1'b1, 2);
        send_request(8'h5a, 1'b0, 1'b0);
        send_message(2, 1'b0, 2);
        // random: messages mostly short, some across block boundaries
        while (req_count < 430) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(54, 57);
                1: len = $urandom_range(62, 66);
                2: len = $urandom_range(100, 130);
                default: len = $urandom_range(0, 20);
            endcase
            if (len > 430 - req_count)
                len = 430 - req_count;
            send_message(len, $urandom_range(0, 3) == 0, 2);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (digests.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (digests.errors == 0)
            $display("PASS sha256_message_digest");
        else
            $display("FAIL sha256_message_digest");
        $finish;
    end

    // timeout
    initial begin
        #4ms;
        $display("FAIL sha256_message_digest");
        $finish;
    end

endmodule

>>> files.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_round.sv
rtl/core/sha256_message_digest.sv
tb/tb_sha256_message_digest.sv
